// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPLY(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Check that an implication holds in the cycle after its trigger.
`define ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: rtl/core/mbsp_pkg.sv
// Types, constants and helpers for the MIDI byte stream parser.
package mbsp_pkg;

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_SINGLE_MIN  = 8'hF4;
    localparam logic [7:0] ST_CLOCK       = 8'hF8;
    localparam logic [7:0] ST_START       = 8'hFA;
    localparam logic [7:0] ST_CONTINUE    = 8'hFB;
    localparam logic [7:0] ST_STOP        = 8'hFC;
    localparam logic [7:0] ST_SONG_SELECT = 8'hF3;
    localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
    localparam logic [3:0] HI_PROGRAM     = 4'hC;
    localparam logic [3:0] HI_PRESSURE    = 4'hD;
    localparam logic [7:0] ST_CHANNEL_MIN = 8'h80;
    localparam logic [15:0] SYSEX_LEN_MAX = 16'hFFFF;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DATA,
        MODE_SYSEX,
        MODE_DROP
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_end;
    } mbsp_item_t;

    typedef struct packed {
        logic        msg_kind;
        logic [7:0]  msg_status;
        logic [7:0]  msg_data1;
        logic [7:0]  msg_data2;
        logic [15:0] sysex_length;
    } mbsp_msg_t;

    // Statuses that carry a single data byte.
    function automatic logic takes_one_data(input logic [7:0] status);
        return (status == ST_SONG_SELECT) || (status == ST_TIME_CODE) ||
               (status[7:4] == HI_PROGRAM) || (status[7:4] == HI_PRESSURE);
    endfunction

endpackage

// File: rtl/core/mbsp_if.sv
// Handshake channels for incoming bytes and outgoing messages.
interface mbsp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_end;

    modport source (output valid, output rx_byte, output packet_end, input ready);
    modport sink   (input valid, input rx_byte, input packet_end, output ready);
endinterface

interface mbsp_msg_if;
    logic        valid;
    logic        ready;
    logic        msg_kind;
    logic [7:0]  msg_status;
    logic [7:0]  msg_data1;
    logic [7:0]  msg_data2;
    logic [15:0] sysex_length;

    modport source (output valid, output msg_kind, output msg_status, output msg_data1,
                    output msg_data2, output sysex_length, input ready);
    modport sink   (input valid, input msg_kind, input msg_status, input msg_data1,
                    input msg_data2, input sysex_length, output ready);
endinterface

// File: rtl/core/mbsp_in_reg.sv
// Input register: captures one byte request and holds it until it is parsed.
module mbsp_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    mbsp_rx_if.sink            rx,
    input  logic               out_free,
    output logic               item_valid,
    output logic               advance,
    output mbsp_pkg::mbsp_item_t item
);
    import mbsp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    mbsp_item_t item_reg;
    logic       accept;

    // Advance the held byte whenever the result register can take its outcome
    assign advance    = valid_reg && out_free;
    assign rx.ready   = !valid_reg || out_free;
    assign accept     = rx.valid && rx.ready;
    assign valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload, load on each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.rx_byte    <= rx.rx_byte;
            item_reg.packet_end <= rx.packet_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// File: rtl/core/mbsp_step.sv
// Parser state machine: one byte per step, running status and sysex length.
module mbsp_step (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  mbsp_pkg::mbsp_item_t   item,
    output logic                   res_valid,
    output mbsp_pkg::mbsp_msg_t    res,
    output mbsp_pkg::parse_mode_t  mode
);
    import mbsp_pkg::*;

    parse_mode_t mode_reg, mode_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  pending_reg, pending_next;
    logic        have_first_reg, have_first_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] sysex_cnt_reg, sysex_cnt_next;

    logic        emit_short;
    logic        emit_sysex;
    logic [7:0]  short_status;
    logic [7:0]  short_d1;
    logic [7:0]  short_d2;
    logic [7:0]  b;
    logic [15:0] sysex_inc;

    assign b         = item.rx_byte;
    assign sysex_inc = (sysex_cnt_reg == SYSEX_LEN_MAX) ? sysex_cnt_reg
                                                        : sysex_cnt_reg + 16'd1;

    // State register, advanced once per parsed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            running_reg    <= '0;
            pending_reg    <= '0;
            have_first_reg <= 1'b0;
            first_reg      <= '0;
            sysex_cnt_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            running_reg    <= running_next;
            pending_reg    <= pending_next;
            have_first_reg <= have_first_next;
            first_reg      <= first_next;
            sysex_cnt_reg  <= sysex_cnt_next;
        end
    end

    // Next state and result for the held byte
    always_comb
    begin
        mode_next       = mode_reg;
        running_next    = running_reg;
        pending_next    = pending_reg;
        have_first_next = have_first_reg;
        first_next      = first_reg;
        sysex_cnt_next  = sysex_cnt_reg;
        emit_short      = 1'b0;
        emit_sysex      = 1'b0;
        short_status    = '0;
        short_d1        = '0;
        short_d2        = '0;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (b == ST_SYSEX_START)
                begin
                    mode_next      = MODE_SYSEX;
                    sysex_cnt_next = 16'd1;
                end
                else if (b >= ST_SINGLE_MIN)
                begin
                    // Pass only the transport and clock real-time bytes
                    if (b inside {ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP})
                    begin
                        emit_short   = 1'b1;
                        short_status = b;
                    end
                end
                else if (b < ST_CHANNEL_MIN)
                begin
                    if (running_reg == '0)
                    begin
                        mode_next = MODE_DROP;
                    end
                    else
                    begin
                        pending_next = running_reg;
                        if (takes_one_data(running_reg))
                        begin
                            emit_short   = 1'b1;
                            short_status = running_reg;
                            short_d1     = b;
                        end
                        else
                        begin
                            first_next      = b;
                            have_first_next = 1'b1;
                            mode_next       = MODE_DATA;
                        end
                    end
                end
                else
                begin
                    pending_next    = b;
                    have_first_next = 1'b0;
                    mode_next       = MODE_DATA;
                end
            end
            MODE_DATA:
            begin
                if (!have_first_reg)
                begin
                    if (takes_one_data(pending_reg))
                    begin
                        emit_short   = 1'b1;
                        short_status = pending_reg;
                        short_d1     = b;
                    end
                    else
                    begin
                        first_next      = b;
                        have_first_next = 1'b1;
                    end
                end
                else
                begin
                    emit_short   = 1'b1;
                    short_status = pending_reg;
                    short_d1     = first_reg;
                    short_d2     = b;
                end
            end
            MODE_SYSEX:
            begin
                sysex_cnt_next = sysex_inc;
                if (b == ST_SYSEX_END)
                begin
                    emit_sysex = 1'b1;
                    mode_next  = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // Close out a short message; channel statuses become running status
        if (emit_short)
        begin
            if (short_status >= ST_CHANNEL_MIN && short_status < ST_SYSEX_START)
            begin
                running_next = short_status;
            end
            mode_next       = MODE_IDLE;
            have_first_next = 1'b0;
        end

        // Drop any partial message at the packet boundary
        if (item.packet_end)
        begin
            mode_next       = MODE_IDLE;
            have_first_next = 1'b0;
        end
    end

    // Assemble the result
    always_comb
    begin
        res_valid = emit_short || emit_sysex;
        if (emit_sysex)
        begin
            res.msg_kind     = KIND_SYSEX;
            res.msg_status   = ST_SYSEX_START;
            res.msg_data1    = '0;
            res.msg_data2    = '0;
            res.sysex_length = sysex_inc;
        end
        else
        begin
            res.msg_kind     = KIND_SHORT;
            res.msg_status   = short_status;
            res.msg_data1    = short_d1;
            res.msg_data2    = short_d2;
            res.sysex_length = '0;
        end
    end

    assign mode = mode_reg;
endmodule

// File: rtl/core/mbsp_out_reg.sv
// Result register: holds one message request until the sink takes it.
module mbsp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                res_valid,
    input  mbsp_pkg::mbsp_msg_t res,
    output logic                out_free,
    mbsp_msg_if.source          msg
);
    import mbsp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    mbsp_msg_t msg_reg;
    logic      load;

    assign out_free   = !valid_reg || msg.ready;
    assign load       = advance && res_valid;
    assign valid_next = load ? 1'b1 : (msg.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new message only when one is produced
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            msg_reg <= res;
        end
    end

    assign msg.valid        = valid_reg;
    assign msg.msg_kind     = msg_reg.msg_kind;
    assign msg.msg_status   = msg_reg.msg_status;
    assign msg.msg_data1    = msg_reg.msg_data1;
    assign msg.msg_data2    = msg_reg.msg_data2;
    assign msg.sysex_length = msg_reg.sysex_length;
endmodule

// File: rtl/core/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser.
//
//   channel  dir  payload                                             per request
//   rx       in   rx_byte[8], packet_end[1]                           one byte
//   msg      out  msg_kind, msg_status, msg_data1, msg_data2,         zero or one
//                 sysex_length[16]                                    per byte
//
// One byte per cycle while msg is not stalled; a message reaches msg through the
// input register, then the result register, once its last byte is accepted.
// rst_n clears the parser to idle with no running status; no clearing pass.
// A stalled msg holds its message; rx keeps accepting while the result register
// is free or being taken in the same cycle.
`include "assert_macros.svh"

module midi_byte_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    mbsp_rx_if.sink    rx,
    mbsp_msg_if.source msg
);
    import mbsp_pkg::*;

    logic        out_free;
    logic        item_valid;
    logic        advance;
    mbsp_item_t  item;
    logic        res_valid;
    mbsp_msg_t   res;
    parse_mode_t mode;

    mbsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .out_free   (out_free),
        .item_valid (item_valid),
        .advance    (advance),
        .item       (item)
    );

    mbsp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res),
        .mode      (mode)
    );

    mbsp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .msg       (msg)
    );

    `ASSERT_IMPLY(a_advance_needs_item, advance, item_valid,
        "parser advanced with no byte held")
    `ASSERT_NEXT(a_packet_end_idles, advance && item.packet_end, mode == MODE_IDLE,
        "parser not idle after packet end")
    `ASSERT_IMPLY(a_sysex_report_shape, msg.valid && (msg.msg_kind == KIND_SYSEX),
        (msg.msg_status == ST_SYSEX_START) && (msg.sysex_length >= 16'd2),
        "sysex report malformed")
    `ASSERT_IMPLY(a_short_no_length, msg.valid && (msg.msg_kind == KIND_SHORT),
        msg.sysex_length == 16'd0, "short message carries a length")
endmodule
